// ===== hw/rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the sample count contrast stretch block.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int unsigned SampleWidth    = 8;
   localparam int unsigned NumWidth       = 2 * SampleWidth;
   localparam int unsigned DivSteps       = SampleWidth;
   localparam int unsigned QueueDepthDflt = 4;

   localparam logic [SampleWidth-1:0] FullScale = 8'd255;

   // pass codes carried on the operation field
   localparam logic OpMeasure = 1'b0;
   localparam logic OpScale   = 1'b1;

   // one scale pass pixel, classified and ready for the divider
   typedef struct packed {
      logic                   direct;         // result known without dividing
      logic [SampleWidth-1:0] direct_value;
      logic [NumWidth-1:0]    numerator;      // 255 * (v - min)
      logic [SampleWidth-1:0] denominator;    // max - min
      logic [SampleWidth-1:0] frame_maximum;
   } item_type;

endpackage

// ===== hw/rtl/scs_front.sv =====
// ----------------------------------------------------------------------------
// scs_front
// Tracks the running range in the measure pass, latches the frame range and
// classifies scale pass pixels into divider jobs.
// ----------------------------------------------------------------------------
module scs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              operation,
   input  logic [scs_pkg::SampleWidth-1:0]   sample_count,
   input  logic                              last_pixel,
   output logic                              push,
   output scs_pkg::item_type                 item
);

   logic [scs_pkg::SampleWidth-1:0] run_min_ff, run_min_in;
   logic [scs_pkg::SampleWidth-1:0] run_max_ff, run_max_in;
   logic [scs_pkg::SampleWidth-1:0] frame_min_ff, frame_min_in;
   logic [scs_pkg::SampleWidth-1:0] frame_max_ff, frame_max_in;
   logic [scs_pkg::SampleWidth-1:0] upd_min, upd_max, diff;

   always_comb begin
      upd_min = (sample_count < run_min_ff) ? sample_count : run_min_ff;
      upd_max = (sample_count > run_max_ff) ? sample_count : run_max_ff;
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      frame_min_in = frame_min_ff;
      frame_max_in = frame_max_ff;
      if (accept && operation == scs_pkg::OpMeasure) begin
         if (last_pixel) begin
            frame_min_in = upd_min;
            frame_max_in = upd_max;
            run_min_in   = scs_pkg::FullScale;
            run_max_in   = '0;
         end else begin
            run_min_in = upd_min;
            run_max_in = upd_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff   <= scs_pkg::FullScale;
         run_max_ff   <= '0;
         frame_min_ff <= '0;
         frame_max_ff <= '0;
      end else begin
         run_min_ff   <= run_min_in;
         run_max_ff   <= run_max_in;
         frame_min_ff <= frame_min_in;
         frame_max_ff <= frame_max_in;
      end
   end

   // classify against the range latched so far
   always_comb begin
      diff               = sample_count - frame_min_ff;
      item.numerator     = {diff, {scs_pkg::SampleWidth{1'b0}}}
                         - {{scs_pkg::SampleWidth{1'b0}}, diff};
      item.denominator   = frame_max_ff - frame_min_ff;
      item.frame_maximum = frame_max_ff;
      item.direct        = 1'b1;
      item.direct_value  = '0;
      if (frame_max_ff == frame_min_ff) begin
         item.direct_value = '0;
      end else if (sample_count <= frame_min_ff) begin
         item.direct_value = '0;
      end else if (sample_count >= frame_max_ff) begin
         item.direct_value = scs_pkg::FullScale;
      end else begin
         item.direct = 1'b0;
      end
   end

   assign push = accept && operation == scs_pkg::OpScale;

endmodule

// ===== hw/rtl/scs_queue.sv =====
// ----------------------------------------------------------------------------
// scs_queue
// Small FIFO of classified items between the front and the divider.
// ----------------------------------------------------------------------------
module scs_queue #(
   parameter int unsigned Depth = scs_pkg::QueueDepthDflt
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scs_pkg::item_type push_item,
   input  logic              pop,
   output scs_pkg::item_type pop_item,
   output logic              full,
   output logic              empty
);

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   scs_pkg::item_type       entry_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign full     = count_ff == CountWidth'(Depth);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/scs_back.sv =====
// ----------------------------------------------------------------------------
// scs_back
// Restoring divider, one quotient bit per cycle, feeding the result register.
// ----------------------------------------------------------------------------
module scs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  scs_pkg::item_type                 queue_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [scs_pkg::SampleWidth-1:0]   rsp_scaled_value,
   output logic [scs_pkg::SampleWidth-1:0]   rsp_frame_maximum
);

   localparam int unsigned W         = scs_pkg::SampleWidth;
   localparam int unsigned StepWidth = $clog2(scs_pkg::DivSteps);

   typedef enum logic [2:0] {
      BACK_IDLE = 3'b001,
      BACK_DIV  = 3'b010,
      BACK_DONE = 3'b100
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [StepWidth-1:0]    step_ff, step_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic [W-1:0]            quo_ff, quo_in;
   logic [W-1:0]            den_ff, den_in;
   logic [W-1:0]            fmax_ff, fmax_in;
   logic                    out_valid_ff, out_valid_in;
   logic [W-1:0]            out_value_ff, out_value_in;
   logic [W-1:0]            out_fmax_ff, out_fmax_in;
   logic [W:0]              trial;
   logic                    fits;
   logic                    out_free;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign trial    = {rem_ff, quo_ff[W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign pop      = state_ff == BACK_IDLE && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      fmax_in      = fmax_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_fmax_in  = out_fmax_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               fmax_in = queue_item.frame_maximum;
               den_in  = queue_item.denominator;
               step_in = '0;
               if (queue_item.direct) begin
                  quo_in   = queue_item.direct_value;
                  state_in = BACK_DONE;
               end else begin
                  // upper half is below the divisor, so the quotient fits W bits
                  rem_in   = queue_item.numerator[2*W-1:W];
                  quo_in   = queue_item.numerator[W-1:0];
                  state_in = BACK_DIV;
               end
            end
         end
         BACK_DIV: begin
            rem_in  = fits ? W'(trial - {1'b0, den_ff}) : trial[W-1:0];
            quo_in  = {quo_ff[W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(scs_pkg::DivSteps - 1)) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = quo_ff;
               out_fmax_in  = fmax_ff;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      den_ff       <= den_in;
      fmax_ff      <= fmax_in;
      out_value_ff <= out_value_in;
      out_fmax_ff  <= out_fmax_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_scaled_value  = out_value_ff;
   assign rsp_frame_maximum = out_fmax_ff;

endmodule

// ===== hw/rtl/sample_count_contrast_stretch.sv =====
// ----------------------------------------------------------------------------
// sample_count_contrast_stretch
// Min-max contrast stretch of an 8-bit sample count image, two passes.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per pixel. operation 0 is a measure pass pixel,
//   which updates the running min/max; with last_pixel set it also latches
//   the frame range and restarts the running pair. Measure beats give no
//   response. operation 1 is a scale pass pixel and gives one rsp_ beat with
//   255*(v-min)/(max-min), truncated and saturated, plus the frame maximum.
//   A scale beat is queued on acceptance; the back end pops it and, when the
//   result is saturated or the range is empty, loads it straight into the
//   output register, else runs the divider over the quotient bits first.
//   Measure beats are taken one per cycle while the queue has room. Scale
//   beats are queued while the back end is busy: its restoring divider
//   retires one quotient bit per cycle and handles one item at a time.
//   Scale beats wait in a QueueDepth-entry queue, classified against the
//   range latched at acceptance, so later measure beats never disturb them.
//   Reset: running min 255, running max 0, frame range 0..0, queue empty,
//   no response pending. A stalled rsp_ beat holds; the divider then waits,
//   and req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module sample_count_contrast_stretch #(
   parameter int unsigned QueueDepth = scs_pkg::QueueDepthDflt
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [scs_pkg::SampleWidth-1:0]   req_sample_count,
   input  logic                              req_last_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [scs_pkg::SampleWidth-1:0]   rsp_scaled_value,
   output logic [scs_pkg::SampleWidth-1:0]   rsp_frame_maximum
);

   logic              accept;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   scs_pkg::item_type push_item;
   scs_pkg::item_type pop_item;

   // stall every beat while the queue is full; measure beats only need the
   // front but hold them too so beat order stays simple
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   scs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .sample_count (req_sample_count),
      .last_pixel   (req_last_pixel),
      .push         (push),
      .item         (push_item)
   );

   scs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   scs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (q_empty),
      .queue_item        (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scaled_value  (rsp_scaled_value),
      .rsp_frame_maximum (rsp_frame_maximum)
   );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample count contrast stretch block. A queue of
// pixel beats feeds a clocked driver. A clocked monitor predicts the stretch
// of each accepted scale beat from its own copy of the running and latched
// ranges, and checks every response beat in order against that prediction.
// ----------------------------------------------------------------------------
module tb;

   typedef logic [scs_pkg::SampleWidth-1:0] sample_type;

   // one pixel beat waiting for the driver
   typedef struct packed {
      logic       operation;
      sample_type sample_count;
      logic       last_pixel;
   } pixel_beat_type;

   // what one scale beat must return
   typedef struct packed {
      sample_type scaled_value;
      sample_type frame_maximum;
   } stretch_result_type;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 40;
   localparam int unsigned ReportLimit = 10;
   localparam int unsigned RandomBeats = 155;   // per idling phase
   localparam int unsigned NumPhases   = 4;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = scs_pkg::OpMeasure;
   sample_type req_sample_count = '0;
   logic       req_last_pixel = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_scaled_value;
   sample_type rsp_frame_maximum;

   // idling percentages of the current phase
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;

   pixel_beat_type     pending_pixels[$];
   stretch_result_type expected_stretch[$];
   pixel_beat_type     next_beat;
   stretch_result_type got_stretch;
   stretch_result_type want_stretch;

   // predictor state: running pair of the open frame, range of the last one
   sample_type  running_min;
   sample_type  running_max;
   sample_type  frame_min;
   sample_type  frame_max;
   sample_type  pred_value;
   logic [15:0] pred_num;

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   sample_count_contrast_stretch dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_sample_count  (req_sample_count),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scaled_value  (rsp_scaled_value),
      .rsp_frame_maximum (rsp_frame_maximum)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count a failure; print only the first few so the log stays short.
   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= ReportLimit) begin
         $display("tb: %s", what);
      end
   endtask

   task automatic push_pixel(input logic op, input int unsigned value, input logic last);
      pixel_beat_type beat;
      beat.operation    = op;
      beat.sample_count = sample_type'(value);
      beat.last_pixel   = last;
      pending_pixels.push_back(beat);
   endtask

   // Build random traffic. Most of it is well-formed: a measure frame drawn
   // from a random window, closed by a last pixel, then scale beats around
   // that window. The rest is noise: stray scale beats with last set, and
   // measure beats that leave a frame open so scale beats interleave with it.
   task automatic add_random_traffic(input int unsigned count);
      int unsigned added;
      int unsigned kind;
      int unsigned lo;
      int unsigned hi;
      int unsigned width;
      int unsigned n;
      int          v;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(9);
         if (kind <= 6) begin
            // pick a window: empty, narrow or anywhere up to full scale
            case ($urandom_range(3))
               0:       width = 0;
               1:       width = $urandom_range(3);
               2:       width = $urandom_range(40);
               default: width = $urandom_range(255);
            endcase
            lo = $urandom_range(255 - width);
            hi = lo + width;
            n  = $urandom_range(8, 1);
            for (int i = 0; i < n; i++) begin
               // the low window edge always appears; the high edge appears when n > 1
               if (i == 0)      v = lo;
               else if (i == 1) v = hi;
               else             v = lo + $urandom_range(width);
               push_pixel(scs_pkg::OpMeasure, v, i == n - 1);
            end
            added += n;
            n = $urandom_range(10, 1);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(3) == 0) begin
                  v = $urandom_range(255);
               end else begin
                  v = int'(lo) - 2 + int'($urandom_range(width + 4));
                  if (v < 0)   v = 0;
                  if (v > 255) v = 255;
               end
               push_pixel(scs_pkg::OpScale, v, $urandom_range(7) == 0);
            end
            added += n;
         end else if (kind == 7) begin
            push_pixel(scs_pkg::OpScale, $urandom_range(255), 1'b1);
            added++;
         end else begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) begin
               push_pixel(scs_pkg::OpMeasure, $urandom_range(255), 1'b0);
            end
            added += n;
         end
      end
   endtask

   // Driver: present a new beat when the slot is empty or the current beat
   // went through; hold the beat otherwise. Also throttle the response side.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
               next_beat = pending_pixels.pop_front();
               req_valid        <= 1'b1;
               req_operation    <= next_beat.operation;
               req_sample_count <= next_beat.sample_count;
               req_last_pixel   <= next_beat.last_pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check the response beat first, then predict from the request
   // beat taken at the same edge, so the order of the two is fixed.
   always @(posedge clock) begin
      if (reset) begin
         running_min <= scs_pkg::FullScale;
         running_max <= '0;
         frame_min   <= '0;
         frame_max   <= '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_stretch.scaled_value  = rsp_scaled_value;
            got_stretch.frame_maximum = rsp_frame_maximum;
            if (expected_stretch.size() == 0) begin
               note_failure($sformatf("response with nothing expected: value %0d max %0d",
                                      rsp_scaled_value, rsp_frame_maximum));
            end else begin
               want_stretch = expected_stretch.pop_front();
               if (got_stretch.scaled_value !== want_stretch.scaled_value) begin
                  note_failure($sformatf("scaled_value mismatch: expected %0d, got %0d",
                                         want_stretch.scaled_value, got_stretch.scaled_value));
               end
               if (got_stretch.frame_maximum !== want_stretch.frame_maximum) begin
                  note_failure($sformatf("frame_maximum mismatch: expected %0d, got %0d",
                                         want_stretch.frame_maximum,
                                         got_stretch.frame_maximum));
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (req_operation == scs_pkg::OpMeasure) begin
               // fold the pixel in; a last pixel latches the pair and reopens it
               if (req_last_pixel) begin
                  frame_min   <= (req_sample_count < running_min) ? req_sample_count
                                                                  : running_min;
                  frame_max   <= (req_sample_count > running_max) ? req_sample_count
                                                                  : running_max;
                  running_min <= scs_pkg::FullScale;
                  running_max <= '0;
               end else begin
                  if (req_sample_count < running_min) running_min <= req_sample_count;
                  if (req_sample_count > running_max) running_max <= req_sample_count;
               end
            end else begin
               // scale against the latched range; saturate outside it
               if (frame_max == frame_min) begin
                  pred_value = '0;
               end else if (req_sample_count <= frame_min) begin
                  pred_value = '0;
               end else if (req_sample_count >= frame_max) begin
                  pred_value = scs_pkg::FullScale;
               end else begin
                  pred_num   = 16'(scs_pkg::FullScale) * 16'(req_sample_count - frame_min);
                  pred_value = sample_type'(pred_num / 16'(frame_max - frame_min));
               end
               want_stretch.scaled_value  = pred_value;
               want_stretch.frame_maximum = frame_max;
               expected_stretch.push_back(want_stretch);
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned phase_idle[NumPhases];
      int unsigned phase_stall[NumPhases];
      phase_idle  = '{0, 50, 0, 7};
      phase_stall = '{0, 0, 50, 7};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats, no idling.
      // Scale before any frame: empty range gives 0 and maximum 0.
      push_pixel(scs_pkg::OpScale, 0, 1'b0);
      push_pixel(scs_pkg::OpScale, 255, 1'b1);
      // Full range 0..255: both ends, middle and the values next to the ends.
      push_pixel(scs_pkg::OpMeasure, 0, 1'b0);
      push_pixel(scs_pkg::OpMeasure, 255, 1'b1);
      push_pixel(scs_pkg::OpScale, 0, 1'b0);
      push_pixel(scs_pkg::OpScale, 255, 1'b0);
      push_pixel(scs_pkg::OpScale, 128, 1'b0);
      push_pixel(scs_pkg::OpScale, 1, 1'b0);
      push_pixel(scs_pkg::OpScale, 254, 1'b0);
      // Single-pixel frame: empty range, everything scales to 0.
      push_pixel(scs_pkg::OpMeasure, 77, 1'b1);
      push_pixel(scs_pkg::OpScale, 77, 1'b0);
      push_pixel(scs_pkg::OpScale, 200, 1'b0);
      // Range 10..20: below, at and above the range, and last set on a scale beat.
      push_pixel(scs_pkg::OpMeasure, 20, 1'b0);
      push_pixel(scs_pkg::OpMeasure, 10, 1'b0);
      push_pixel(scs_pkg::OpMeasure, 15, 1'b1);
      push_pixel(scs_pkg::OpScale, 5, 1'b0);
      push_pixel(scs_pkg::OpScale, 10, 1'b0);
      push_pixel(scs_pkg::OpScale, 15, 1'b0);
      push_pixel(scs_pkg::OpScale, 20, 1'b0);
      push_pixel(scs_pkg::OpScale, 30, 1'b0);
      push_pixel(scs_pkg::OpScale, 15, 1'b1);
      // One-step range at the top.
      push_pixel(scs_pkg::OpMeasure, 255, 1'b0);
      push_pixel(scs_pkg::OpMeasure, 254, 1'b1);
      push_pixel(scs_pkg::OpScale, 254, 1'b0);
      push_pixel(scs_pkg::OpScale, 255, 1'b0);
      // Zero frame.
      push_pixel(scs_pkg::OpMeasure, 0, 1'b1);
      push_pixel(scs_pkg::OpScale, 0, 1'b0);

      // Random traffic, one batch per idling phase; wait for each to go out.
      for (int p = 0; p < NumPhases; p++) begin
         while (pending_pixels.size() != 0 || req_valid) @(posedge clock);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         add_random_traffic(RandomBeats);
      end
      while (pending_pixels.size() != 0 || req_valid) @(posedge clock);

      // Drain: wait for every prediction to be met, then catch stragglers.
      while (expected_stretch.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
